// ===== rtl/bgtp_pkg.sv =====
// ----------------------------------------------------------------------------
// bgtp_pkg: shared constants and functions for the go-to-point step
// Holds the fixed-point constants, the CORDIC arctangent table and register codes.
// ----------------------------------------------------------------------------
package bgtp_pkg;

  localparam int unsigned CordicIterDefault = 18;

  localparam logic signed [20:0] PiQ16    = 21'sd205887;
  localparam logic signed [20:0] TwoPiQ16 = 21'sd411775;
  localparam logic signed [27:0] PiQ24    = 28'sd52707179;
  localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [16:0] SteerLim = 17'sd34315;
  localparam logic signed [33:0] CordicKQ30 = 34'sd652032874;

  localparam logic [2:0] RegGoalX  = 3'd0;
  localparam logic [2:0] RegGoalY  = 3'd1;
  localparam logic [2:0] RegSpeed  = 3'd2;
  localparam logic [2:0] RegKp     = 3'd3;
  localparam logic [2:0] RegKd     = 3'd4;
  localparam logic [2:0] RegWheel  = 3'd5;

  localparam logic [1:0] OpAtan = 2'd0;
  localparam logic [1:0] OpRot  = 2'd1;

  function automatic logic signed [27:0] atan_step(input logic [4:0] i);
    logic signed [27:0] r;
    case (i)
      5'd0: r = 28'sd13176795;
      5'd1: r = 28'sd7778716;
      5'd2: r = 28'sd4110060;
      5'd3: r = 28'sd2086331;
      5'd4: r = 28'sd1047214;
      5'd5: r = 28'sd524117;
      5'd6: r = 28'sd262123;
      5'd7: r = 28'sd131069;
      default: r = 28'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

  // floor shift toward minus infinity
  function automatic logic signed [35:0] asr36(input logic signed [35:0] v,
                                               input logic [4:0] s);
    return v >>> s;
  endfunction

endpackage

// ===== rtl/bgtp_cordic.sv =====
// ----------------------------------------------------------------------------
// bgtp_cordic: shared iterative CORDIC
// Vectoring (atan2) or rotation (cos/sin), one iteration per cycle.
// ----------------------------------------------------------------------------
module bgtp_cordic import bgtp_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic signed [27:0] z_i,
  output logic               done_o,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic signed [27:0] z_o
);

  localparam int unsigned IterW = 5;
  localparam logic [IterW-1:0] LastIter = IterW'(CordicIterations - 1);

  logic               busy_q, busy_d;
  logic [IterW-1:0]   it_q, it_d;
  logic [1:0]         op_q, op_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [27:0] z_q, z_d;
  logic               done_q, done_d;
  logic               dir;
  logic signed [35:0] xs, ys;

  always_comb begin
    xs = asr36(x_q, it_q);
    ys = asr36(y_q, it_q);
    dir = (op_q == OpAtan) ? (y_q > 0) : (z_q >= 0);
    busy_d = busy_q;
    it_d = it_q;
    op_d = op_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      it_d = '0;
      op_d = op_i;
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (busy_q) begin
      if ((op_q == OpAtan) == dir) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
      end
      if (dir) z_d = (op_q == OpAtan) ? z_q + atan_step(it_q) : z_q - atan_step(it_q);
      else     z_d = (op_q == OpAtan) ? z_q - atan_step(it_q) : z_q + atan_step(it_q);
      it_d = it_q + 1'b1;
      if (it_q == LastIter) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q <= '0;
      op_q <= OpAtan;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q <= it_d;
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ===== rtl/bgtp_div.sv =====
// ----------------------------------------------------------------------------
// bgtp_div: serial restoring divider
// Unsigned magnitude quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module bgtp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [35:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [63:0] q_q;
  logic [36:0] r_q;
  logic [35:0] d_q;
  logic        done_q;
  logic [36:0] r_sh;
  logic [37:0] diff;

  assign r_sh = {r_q[35:0], q_q[63]};
  assign diff = {1'b0, r_sh} - {2'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      if (!diff[37]) begin
        r_q <= diff[36:0];
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o = q_q;

endmodule

// ===== rtl/bicycle_go_to_point_step.sv =====
// A request runs three CORDIC passes, two serial divides, a heading reduction and
// plain sequencer steps between them; an arrival or a restart goes straight to the result.
// One request at a time; s_axis_tready is low while busy and while the result waits,
// so the next request is taken only after the result has been accepted.
// Reset clears pose, heading and last error and loads register defaults.
// ----------------------------------------------------------------------------
// bicycle_go_to_point_step: go-to-point control step of a kinematic bicycle
// Sequencer around a shared CORDIC, a serial divider and one multiplier.
// ----------------------------------------------------------------------------
module bicycle_go_to_point_step import bgtp_pkg::*; #(
  parameter int unsigned CordicIterations = CordicIterDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [0] restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [82:64] heading, [99:83] steer, [100] arrived
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [4:0] SIdle = 5'd0, SDist = 5'd1, SDist2 = 5'd2, SAtan = 5'd3,
    SAtanW = 5'd4, SErr = 5'd5, SPd1 = 5'd6, SPd2 = 5'd7, SClamp = 5'd8,
    SRot1 = 5'd9, SRot1W = 5'd10, STan = 5'd11, STanW = 5'd12, SDth = 5'd13,
    SDthW = 5'd14, SHead = 5'd15, SRot2 = 5'd16, SRot2W = 5'd17, SPosX = 5'd18,
    SPosY = 5'd19, SOut = 5'd20, SHold = 5'd21, SDist3 = 5'd22, SMod = 5'd23,
    SWrap = 5'd24;

  logic [4:0] st_q, st_d;
  logic signed [31:0] gx_q, gy_q;
  logic [15:0] spd_q, whl_q;
  logic signed [15:0] kp_q, kd_q;
  logic signed [31:0] px_q, py_q;
  logic signed [18:0] hd_q, pe_q;
  logic signed [16:0] steer_q;
  logic arrived_q;
  logic signed [17:0] a_q;
  logic signed [31:0] b_q;
  logic signed [63:0] acc_q;
  logic signed [35:0] c_q, s_q;
  logic signed [33:0] dx_q, dy_q;
  logic signed [20:0] err_q;
  logic [103:0] out_q;
  logic out_v_q;
  logic [29:0] md_q;
  logic md_neg_q;
  logic [3:0] mk_q;
  logic [29:0] msub;
  logic near_now;

  logic signed [49:0] prod;
  assign prod = a_q * b_q;

  logic cs_start;
  logic [1:0] cs_op;
  logic signed [35:0] cs_x, cs_y, co_x, co_y;
  logic signed [27:0] cs_z, co_z;
  logic cs_done;

  bgtp_cordic #(.CordicIterations(CordicIterations)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .op_i(cs_op), .x_i(cs_x), .y_i(cs_y),
    .z_i(cs_z), .done_o(cs_done), .x_o(co_x), .y_o(co_y), .z_o(co_z)
  );

  logic dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  logic [35:0] dv_den;
  logic dv_neg_q;

  bgtp_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  function automatic logic signed [63:0] rsh64(input logic signed [63:0] v,
                                               input logic [5:0] s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 6'd1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [20:0] wrap(input logic signed [21:0] a);
    logic signed [21:0] r;
    r = a;
    if (r > 22'(PiQ16)) r = r - 22'(TwoPiQ16);
    if (r < -22'(PiQ16)) r = r + 22'(TwoPiQ16);
    return r[20:0];
  endfunction

  logic signed [63:0] tmp;
  logic signed [27:0] zin;
  logic sc_neg_q;

  always_comb begin
    cs_start = 1'b0;
    cs_op = OpRot;
    cs_x = '0;
    cs_y = '0;
    cs_z = '0;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    zin = '0;
    tmp = '0;
    if (st_q == SAtan) begin
      cs_start = 1'b1;
      cs_op = OpAtan;
      if (dx_q < 0) begin
        if (dy_q >= 0) begin
          cs_x = 36'(dy_q); cs_y = -36'(dx_q); cs_z = HalfPiQ24;
        end else begin
          cs_x = -36'(dy_q); cs_y = 36'(dx_q); cs_z = -HalfPiQ24;
        end
      end else begin
        cs_x = 36'(dx_q); cs_y = 36'(dy_q);
      end
    end
    if (st_q == SRot1 || st_q == SRot2) begin
      zin = (st_q == SRot1) ? 28'(steer_q) <<< 8 : 28'(hd_q) <<< 8;
      cs_start = 1'b1;
      cs_x = 36'(CordicKQ30);
      if (zin > HalfPiQ24) cs_z = zin - PiQ24;
      else if (zin < -HalfPiQ24) cs_z = zin + PiQ24;
      else cs_z = zin;
    end
    if (st_q == STan) begin
      tmp = 64'(s_q) <<< 16;
      dv_start = 1'b1;
      dv_num = tmp[63] ? 64'(-tmp) : 64'(tmp);
      dv_num = dv_num + (64'(c_q[35] ? -c_q : c_q) >> 1);
      dv_den = c_q[35] ? 36'(-c_q) : 36'(c_q);
    end
    if (st_q == SDth) begin
      dv_start = 1'b1;
      dv_num = prod[49] ? 64'(-prod) : 64'(prod);
      tmp = 64'(25) * 64'((whl_q == 16'd0) ? 16'd1 : whl_q);
      dv_num = dv_num + (tmp >> 1);
      dv_den = tmp[35:0];
    end
  end

  logic signed [29:0] hsum;
  logic signed [32:0] psum;
  logic signed [63:0] pd_sum;

  assign hsum = 30'(hd_q) + 30'(acc_q);
  assign psum = ((st_q == SPosY) ? 33'(py_q) : 33'(px_q)) + 33'(rsh64(64'(prod), 6'd31));
  assign pd_sum = rsh64(acc_q + 64'(prod), 6'd8);
  assign msub = 30'(TwoPiQ16) << mk_q;
  assign near_now = !(dx_q > 256 || dx_q < -256 || dy_q > 256 || dy_q < -256) &&
                    (acc_q + 64'(prod) <= 64'sd65536);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle:  if (s_axis_tvalid && s_axis_tready) st_d = s_axis_tdata[0] ? SOut : SDist;
      SDist:  st_d = SDist2;
      SDist2: st_d = SDist3;
      SDist3: st_d = near_now ? SOut : SAtan;
      SAtan:  st_d = SAtanW;
      SAtanW: if (cs_done) st_d = SErr;
      SErr:   st_d = SPd1;
      SPd1:   st_d = SPd2;
      SPd2:   st_d = SClamp;
      SClamp: st_d = SRot1;
      SRot1:  st_d = SRot1W;
      SRot1W: if (cs_done) st_d = STan;
      STan:   st_d = STanW;
      STanW:  if (dv_done) st_d = SDth;
      SDth:   st_d = SDthW;
      SDthW:  if (dv_done) st_d = SHead;
      SHead:  st_d = SMod;
      SMod:   if (mk_q == 4'd0) st_d = SWrap;
      SWrap:  st_d = SRot2;
      SRot2:  st_d = SRot2W;
      SRot2W: if (cs_done) st_d = SPosX;
      SPosX:  st_d = SPosY;
      SPosY:  st_d = SOut;
      SOut:   st_d = SHold;
      SHold:  if (!out_v_q) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  assign s_axis_tready = (st_q == SIdle) && !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      gx_q <= 32'sd256000; gy_q <= 32'sd179200; spd_q <= 16'd1280;
      kp_q <= 16'sd256; kd_q <= 16'sd0; whl_q <= 16'd1085;
      px_q <= '0; py_q <= '0; hd_q <= '0; pe_q <= '0;
      out_v_q <= 1'b0;
      steer_q <= '0;
      arrived_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegGoalX: gx_q <= cfg_data_i;
          RegGoalY: gy_q <= cfg_data_i;
          RegSpeed: spd_q <= cfg_data_i[15:0];
          RegKp:    kp_q <= cfg_data_i[15:0];
          RegKd:    kd_q <= cfg_data_i[15:0];
          RegWheel: whl_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      unique case (st_q)
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          steer_q <= '0;
          arrived_q <= 1'b0;
          if (s_axis_tdata[0]) begin
            px_q <= '0; py_q <= '0; hd_q <= '0; pe_q <= '0;
          end else begin
            dx_q <= 34'(gx_q) - 34'(px_q);
            dy_q <= 34'(gy_q) - 34'(py_q);
          end
        end
        SDist: begin
          a_q <= 18'(dx_q);
          b_q <= 32'(dx_q);
        end
        SDist2: begin
          acc_q <= 64'(prod);
          a_q <= 18'(dy_q);
          b_q <= 32'(dy_q);
        end
        SDist3: arrived_q <= near_now;
        SErr: err_q <= wrap(22'(rsh64(64'(co_z), 6'd8)) - 22'(hd_q));
        SPd1: begin
          a_q <= 18'(kp_q); b_q <= 32'(err_q);
        end
        SPd2: begin
          acc_q <= 64'(prod);
          a_q <= 18'(kd_q); b_q <= 32'(err_q) - 32'(pe_q);
        end
        SClamp: begin
          if (pd_sum > 64'(SteerLim)) steer_q <= SteerLim;
          else if (pd_sum < -64'(SteerLim)) steer_q <= -SteerLim;
          else steer_q <= pd_sum[16:0];
        end
        SRot1, SRot2: sc_neg_q <= (zin > HalfPiQ24) || (zin < -HalfPiQ24);
        SRot1W: if (cs_done) begin
          c_q <= sc_neg_q ? -co_x : co_x;
          s_q <= sc_neg_q ? -co_y : co_y;
        end
        STan: dv_neg_q <= s_q[35] ^ c_q[35];
        STanW: if (dv_done) begin
          a_q <= $signed({1'b0, spd_q, 1'b0});
          b_q <= dv_neg_q ? -$signed(dv_quo[31:0]) : $signed(dv_quo[31:0]);
        end
        SDth: begin
          acc_q <= 64'(prod);
          dv_neg_q <= prod[49];
        end
        SDthW: if (dv_done) acc_q <= dv_neg_q ? -$signed(dv_quo) : $signed(dv_quo);
        SHead: begin
          md_q <= hsum[29] ? 30'(-hsum) : 30'(hsum);
          md_neg_q <= hsum[29];
          mk_q <= 4'd10;
        end
        SMod: begin
          if (md_q >= msub) md_q <= md_q - msub;
          mk_q <= mk_q - 1'b1;
        end
        SWrap: begin
          hd_q <= 19'(wrap(md_neg_q ? -22'(md_q) : 22'(md_q)));
          pe_q <= err_q[18:0];
        end
        SRot2W: if (cs_done) begin
          c_q <= sc_neg_q ? -co_x : co_x;
          s_q <= sc_neg_q ? -co_y : co_y;
          a_q <= $signed({2'b0, spd_q});
          b_q <= 32'(sc_neg_q ? -co_x : co_x);
        end
        SPosX: begin
          px_q <= (psum > 33'sd2147483647) ? 32'sh7fffffff :
                  (psum < -33'sd2147483648) ? 32'sh80000000 : psum[31:0];
          b_q <= 32'(s_q);
        end
        SPosY: begin
          py_q <= (psum > 33'sd2147483647) ? 32'sh7fffffff :
                  (psum < -33'sd2147483648) ? 32'sh80000000 : psum[31:0];
        end
        SOut: begin
          out_q <= {3'b0, arrived_q, steer_q, hd_q, py_q, px_q};
          out_v_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

endmodule

// ===== rtl/bgtp_checker.sv =====
// ----------------------------------------------------------------------------
// bgtp_checker: port checks for the go-to-point step
// Watches the streaming ports over time.
// ----------------------------------------------------------------------------
module bgtp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while busy");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accepting while result pending");

endmodule

bind bicycle_go_to_point_step bgtp_checker u_chk (.*);
